/* rtl/core/xild_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package xild_pkg;

  localparam int unsigned CodeW = 8;
  localparam int unsigned LenW  = 5;
  localparam int unsigned CntW  = 5;
  localparam int unsigned PendW = 4;

  localparam logic [7:0] FlagMr = 8'h10;
  localparam logic [7:0] FlagOs = 8'h20;
  localparam logic [7:0] FlagNx = 8'h40;

  localparam logic [7:0] OpEscape  = 8'h0F;
  localparam logic [7:0] OpOpsize  = 8'h66;
  localparam logic [7:0] OpGrp3B   = 8'hF6;
  localparam logic [7:0] OpGrp3V   = 8'hF7;
  localparam logic [7:0] RegMask   = 8'h38;
  localparam logic [3:0] MaxPrefix = 4'd15;

  typedef enum logic [2:0] {
    PH_OPCODE = 3'd0,
    PH_SECOND = 3'd1,
    PH_MODRM  = 3'd2,
    PH_SIB    = 3'd3,
    PH_TAIL   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    G3_NONE = 2'd0,
    G3_BYTE = 2'd1,
    G3_WORD = 2'd2
  } grp3_e;

  typedef struct packed {
    logic [CodeW-1:0] code_byte;
    logic             resync;
  } xild_in_t;

  typedef struct packed {
    logic [LenW-1:0] length;
    logic            not_handled;
  } xild_out_t;

  function automatic logic [7:0] rom_one(input logic [7:0] b);
    logic [7:0] r;
    logic [3:0] lo;
    lo = b[3:0];
    r = 8'h01;
    if (b < 8'h40) begin
      case (lo[2:0])
        3'd4: r = 8'h02;
        3'd5: r = FlagOs + 8'h01;
        3'd6, 3'd7: r = (b == OpEscape) ? 8'h00 : 8'h01;
        default: r = FlagMr + 8'h01;
      endcase
      if (b == OpEscape) r = 8'h00;
    end else if (b < 8'h60) begin
      r = 8'h01;
    end else if (b < 8'h70) begin
      case (lo)
        4'h2, 4'h3: r = FlagMr + 8'h01;
        4'h6: r = 8'h00;
        4'h7: r = FlagNx;
        4'h8: r = FlagOs + 8'h01;
        4'h9: r = FlagMr + FlagOs + 8'h01;
        4'hA: r = 8'h02;
        4'hB: r = FlagMr + 8'h02;
        4'hC: r = 8'h02;
        4'hD: r = FlagOs + 8'h01;
        4'hE: r = 8'h02;
        4'hF: r = FlagOs + 8'h01;
        default: r = 8'h01;
      endcase
    end else if (b < 8'h80) begin
      r = 8'h02;
    end else if (b < 8'h90) begin
      case (lo)
        4'h0: r = FlagMr + 8'h02;
        4'h1: r = FlagMr + FlagOs + 8'h01;
        4'h2: r = 8'h02;
        4'h3: r = FlagMr + 8'h02;
        default: r = FlagMr + 8'h01;
      endcase
    end else if (b < 8'hA0) begin
      r = (lo == 4'hA) ? FlagOs + 8'h03 : 8'h01;
    end else if (b < 8'hB0) begin
      case (lo)
        4'h0, 4'h2, 4'h8, 4'hA: r = 8'h02;
        4'h1, 4'h3, 4'h9, 4'hB: r = FlagOs + 8'h01;
        default: r = 8'h01;
      endcase
    end else if (b < 8'hC0) begin
      r = lo[3] ? FlagOs + 8'h01 : 8'h02;
    end else if (b < 8'hD0) begin
      case (lo)
        4'h0, 4'h1, 4'h6: r = FlagMr + 8'h02;
        4'h2, 4'hA: r = 8'h03;
        4'h4, 4'h5: r = FlagMr + FlagOs + 8'h03;
        4'h7: r = FlagMr + FlagOs + 8'h01;
        4'h8: r = 8'h04;
        4'hD: r = 8'h02;
        default: r = 8'h01;
      endcase
    end else if (b < 8'hE0) begin
      case (lo)
        4'h4, 4'h5, 4'h7: r = 8'h01;
        4'h6: r = FlagNx;
        default: r = FlagMr + 8'h01;
      endcase
    end else if (b < 8'hF0) begin
      case (lo)
        4'h8, 4'h9: r = FlagOs + 8'h01;
        4'hA: r = FlagOs + 8'h03;
        4'hB: r = 8'h02;
        default: r = lo[3] ? 8'h01 : 8'h02;
      endcase
    end else begin
      case (lo)
        4'h1: r = FlagNx;
        4'h6, 4'h7, 4'hE, 4'hF: r = FlagMr + 8'h01;
        default: r = 8'h01;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] rom_two(input logic [7:0] b);
    logic [7:0] r;
    logic [3:0] lo;
    lo = b[3:0];
    r = FlagNx;
    case (b[7:4])
      4'h0: begin
        case (lo)
          4'h0, 4'h1, 4'h2, 4'h3: r = FlagMr + 8'h02;
          4'h6, 4'h8, 4'h9: r = 8'h02;
          default: r = FlagNx;
        endcase
      end
      4'h2: begin
        case (lo)
          4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h6: r = 8'h02;
          default: r = FlagNx;
        endcase
      end
      4'h3: r = (lo < 4'h3) ? 8'h02 : FlagNx;
      4'h8: r = FlagOs + 8'h02;
      4'h9: r = lo[3] ? FlagMr + 8'h02 : 8'h02;
      4'hA: begin
        case (lo)
          4'h0, 4'h1, 4'h2, 4'h8, 4'h9, 4'hA: r = 8'h02;
          4'h3, 4'h5, 4'hB, 4'hD, 4'hF: r = FlagMr + 8'h02;
          4'h4, 4'hC: r = FlagMr + 8'h03;
          default: r = FlagNx;
        endcase
      end
      4'hB: begin
        case (lo)
          4'h2, 4'h4, 4'h5: r = FlagMr + FlagOs + 8'h02;
          4'h8, 4'h9: r = FlagNx;
          4'hA: r = FlagMr + 8'h03;
          default: r = FlagMr + 8'h02;
        endcase
      end
      4'hC: begin
        case (lo)
          4'h0, 4'h1: r = FlagMr + 8'h02;
          default: r = lo[3] ? 8'h02 : FlagNx;
        endcase
      end
      default: r = FlagNx;
    endcase
    return r;
  endfunction

  function automatic logic is_prefix(input logic [7:0] b);
    return b == 8'h66 || b == 8'hF0 || b == 8'hF2 || b == 8'hF3 ||
           b == 8'h26 || b == 8'h2E || b == 8'h36 || b == 8'h3E ||
           b == 8'h64 || b == 8'h65;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/xild_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface xild_in_if;
  logic                valid;
  logic                ready;
  xild_pkg::xild_in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface xild_out_if;
  logic                valid;
  logic                ready;
  xild_pkg::xild_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/xild_step.sv */
`timescale 1ns / 1ps
`default_nettype none
module xild_step (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire xild_pkg::xild_in_t in_i,
  output logic                   done_o,
  output xild_pkg::xild_out_t    res_o
);
  import xild_pkg::*;

  phase_e           phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             short_q, short_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic [1:0]       flags_q, flags_d;
  grp3_e            g3_q, g3_d;
  logic [1:0]       mod_q, mod_d;

  always_comb begin
    phase_e           ph;
    logic [CntW-1:0]  cnt;
    logic             shrt;
    logic [PendW-1:0] pend;
    grp3_e            g3;
    logic [1:0]       md;
    logic [7:0]       b, entry;
    logic [3:0]       opb, fixed, imm, opsz, extra;
    logic             do_lookup, clr;
    logic [CntW-1:0]  pre;

    b = in_i.code_byte;
    ph = phase_q; cnt = cnt_q; shrt = short_q; pend = pend_q;
    g3 = g3_q; md = mod_q;
    flags_d = flags_q;
    if (in_i.resync) begin
      ph = PH_OPCODE; cnt = '0; shrt = 1'b0; pend = '0;
      g3 = G3_NONE; md = '0; flags_d = '0;
    end
    opsz = shrt ? 4'd2 : 4'd4;
    done_o = 1'b0;
    res_o = '0;
    clr = 1'b0;
    do_lookup = 1'b0;
    entry = rom_one(b);
    opb = 4'd1;
    extra = '0;
    fixed = '0;
    imm = '0;
    pre = '0;

    case (ph)
      PH_SECOND: begin
        cnt = cnt + 1'b1;
        entry = rom_two(b);
        opb = 4'd2;
        do_lookup = 1'b1;
      end
      PH_MODRM: begin
        cnt = cnt + 1'b1;
        if (b[7:6] == 2'd1) extra = 4'd1;
        else if (b[7:6] == 2'd2) extra = 4'd4;
        else if (b[7:6] == 2'd0 && b[2:0] == 3'd5) extra = 4'd4;
        if ((b & RegMask) == 8'h00) begin
          if (g3 == G3_BYTE) extra = extra + 4'd1;
          else if (g3 == G3_WORD) extra = extra + opsz;
        end
        pend = pend + extra;
        md = b[7:6];
        if (b[7:6] != 2'd3 && b[2:0] == 3'd4) ph = PH_SIB;
        else if (pend == '0) begin done_o = 1'b1; res_o.length = cnt; clr = 1'b1; end
        else ph = PH_TAIL;
      end
      PH_SIB: begin
        cnt = cnt + 1'b1;
        if (md == 2'd0 && b[2:0] == 3'd5) pend = pend + 4'd4;
        if (pend == '0) begin done_o = 1'b1; res_o.length = cnt; clr = 1'b1; end
        else ph = PH_TAIL;
      end
      PH_TAIL: begin
        cnt = cnt + 1'b1;
        if (pend != '0) pend = pend - 1'b1;
        if (pend == '0) begin done_o = 1'b1; res_o.length = cnt; clr = 1'b1; end
        else ph = PH_TAIL;
      end
      default: begin
        if (is_prefix(b)) begin
          if (b == OpOpsize) shrt = 1'b1;
          if (cnt < CntW'(MaxPrefix)) cnt = cnt + 1'b1;
          ph = PH_OPCODE;
        end else begin
          cnt = cnt + 1'b1;
          if (b == OpEscape) ph = PH_SECOND;
          else begin
            g3 = (b == OpGrp3B) ? G3_BYTE : ((b == OpGrp3V) ? G3_WORD : G3_NONE);
            do_lookup = 1'b1;
          end
        end
      end
    endcase

    if (do_lookup) begin
      fixed = entry[3:0];
      if ((entry & FlagNx) != 8'h00) begin
        pre = (cnt >= CntW'(opb)) ? cnt - CntW'(opb) : '0;
        done_o = 1'b1; res_o.length = pre; res_o.not_handled = 1'b1; clr = 1'b1;
      end else begin
        imm = (fixed > opb) ? fixed - opb : '0;
        if ((entry & FlagOs) != 8'h00) imm = imm + opsz;
        flags_d = entry[5:4];
        pend = imm;
        if ((entry & FlagMr) != 8'h00) ph = PH_MODRM;
        else if (pend == '0) begin done_o = 1'b1; res_o.length = cnt; clr = 1'b1; end
        else ph = PH_TAIL;
      end
    end

    if (clr) begin
      ph = PH_OPCODE; cnt = '0; shrt = 1'b0; pend = '0;
      g3 = G3_NONE; md = '0; flags_d = '0;
    end
    phase_d = ph; cnt_d = cnt; short_d = shrt; pend_d = pend; g3_d = g3; mod_d = md;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPCODE;
      cnt_q   <= '0;
      short_q <= 1'b0;
      pend_q  <= '0;
      flags_q <= '0;
      g3_q    <= G3_NONE;
      mod_q   <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      short_q <= short_d;
      pend_q  <= pend_d;
      flags_q <= flags_d;
      g3_q    <= g3_d;
      mod_q   <= mod_d;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/x86_instruction_length_decoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload
// in_if     in   code_byte[7:0], resync
// out_if    out  length[4:0], not_handled
//
// One code byte a cycle while in_if is ready; the decode state advances in the cycle the beat is taken.
// A finished length sits in the output register in the cycle after its last byte is taken.
// Reset clears all decode state; the output register comes up empty.
// Input is held off only while the output register is full and stalled.
module x86_instruction_length_decoder_top (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  xild_in_if.sink    in_if,
  xild_out_if.source out_if
);
  import xild_pkg::*;

  logic      take, done;
  xild_out_t res;
  logic      vld_q;
  xild_out_t res_q;

  assign in_if.ready = !vld_q || out_if.ready;
  assign take = in_if.valid && in_if.ready;

  xild_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (take),
    .in_i   (in_if.payload),
    .done_o (done),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_if.ready) begin
      vld_q <= take && done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && done) begin
      res_q <= res;
    end
  end

  assign out_if.valid   = vld_q;
  assign out_if.payload = res_q;
endmodule
`default_nettype wire

/* rtl/core/xild_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module xild_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [4:0] out_length_i,
  input wire logic       out_nh_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_length_i) && $stable(out_nh_i))
    else $error("result dropped or changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input held off with empty output");
  a_nolen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_nh_i |-> out_length_i != 5'd0)
    else $error("zero length result");
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without input beat");
endmodule

bind x86_instruction_length_decoder_top xild_checker u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_length_i (out_if.payload.length),
  .out_nh_i     (out_if.payload.not_handled)
);
`default_nettype wire

/* tb/x86_instruction_length_decoder_checker.sv */
`timescale 1ns / 1ps
module x86_instruction_length_decoder_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  xild_in_if.sink      in_mon,
  xild_out_if.sink     out_mon,
  output int unsigned  fail_count_o,
  output int unsigned  lengths_pending_o
);
  import xild_pkg::*;

  // one-byte opcode map, packed by row
  localparam byte unsigned MR = 8'h10;
  localparam byte unsigned OS = 8'h20;
  localparam byte unsigned NX = 8'h40;

  byte unsigned map_one [256];
  byte unsigned map_two [256];

  phase_e      ph;
  logic [4:0]  seen;
  logic        short_ops;
  logic [3:0]  pend;
  grp3_e       g3;
  logic [1:0]  modf;

  xild_out_t   lengths_q[$];

  initial begin
    map_one = '{
      MR+1,MR+1,MR+1,MR+1,2,OS+1,1,1, MR+1,MR+1,MR+1,MR+1,2,OS+1,1,0,
      MR+1,MR+1,MR+1,MR+1,2,OS+1,1,1, MR+1,MR+1,MR+1,MR+1,2,OS+1,1,1,
      MR+1,MR+1,MR+1,MR+1,2,OS+1,1,1, MR+1,MR+1,MR+1,MR+1,2,OS+1,1,1,
      MR+1,MR+1,MR+1,MR+1,2,OS+1,1,1, MR+1,MR+1,MR+1,MR+1,2,OS+1,1,1,
      1,1,1,1,1,1,1,1, 1,1,1,1,1,1,1,1,
      1,1,1,1,1,1,1,1, 1,1,1,1,1,1,1,1,
      1,1,MR+1,MR+1,1,1,0,NX, OS+1,MR+OS+1,2,MR+2,2,OS+1,2,OS+1,
      2,2,2,2,2,2,2,2, 2,2,2,2,2,2,2,2,
      MR+2,MR+OS+1,2,MR+2,MR+1,MR+1,MR+1,MR+1,
      MR+1,MR+1,MR+1,MR+1,MR+1,MR+1,MR+1,MR+1,
      1,1,1,1,1,1,1,1, 1,1,OS+3,1,1,1,1,1,
      2,OS+1,2,OS+1,1,1,1,1, 2,OS+1,2,OS+1,1,1,1,1,
      2,2,2,2,2,2,2,2, OS+1,OS+1,OS+1,OS+1,OS+1,OS+1,OS+1,OS+1,
      MR+2,MR+2,3,1,MR+OS+3,MR+OS+3,MR+2,MR+OS+1, 4,1,3,1,1,2,1,1,
      MR+1,MR+1,MR+1,MR+1,1,1,NX,1, MR+1,MR+1,MR+1,MR+1,MR+1,MR+1,MR+1,MR+1,
      2,2,2,2,2,2,2,2, OS+1,OS+1,OS+3,2,1,1,1,1,
      1,NX,1,1,1,1,MR+1,MR+1, 1,1,1,1,1,1,MR+1,MR+1
    };
    foreach (map_two[i]) map_two[i] = NX;
    for (int i = 0; i < 4; i++) map_two[i] = MR + 2;
    map_two[8'h06] = 2; map_two[8'h08] = 2; map_two[8'h09] = 2;
    for (int i = 8'h20; i <= 8'h24; i++) map_two[i] = 2;
    map_two[8'h26] = 2;
    for (int i = 8'h30; i <= 8'h32; i++) map_two[i] = 2;
    for (int i = 8'h80; i <= 8'h8F; i++) map_two[i] = OS + 2;
    for (int i = 8'h90; i <= 8'h9F; i++) map_two[i] = (i >= 8'h98) ? MR + 2 : 2;
    for (int i = 8'hA0; i <= 8'hAF; i++) begin
      case (i & 15)
        0, 1, 2, 8, 9, 10: map_two[i] = 2;
        3, 5, 11, 13, 15: map_two[i] = MR + 2;
        4, 12: map_two[i] = MR + 3;
        default: map_two[i] = NX;
      endcase
    end
    for (int i = 8'hB0; i <= 8'hBF; i++) begin
      case (i & 15)
        2, 4, 5: map_two[i] = MR + OS + 2;
        8, 9: map_two[i] = NX;
        10: map_two[i] = MR + 3;
        default: map_two[i] = MR + 2;
      endcase
    end
    map_two[8'hC0] = MR + 2; map_two[8'hC1] = MR + 2;
    for (int i = 8'hC8; i <= 8'hCF; i++) map_two[i] = 2;
  end

  function automatic bit prefix_byte(input logic [7:0] b);
    return b == 8'h66 || b == 8'hF0 || b == 8'hF2 || b == 8'hF3 ||
           b == 8'h26 || b == 8'h2E || b == 8'h36 || b == 8'h3E ||
           b == 8'h64 || b == 8'h65;
  endfunction

  function automatic int unsigned opnd_bytes();
    return short_ops ? 2 : 4;
  endfunction

  task automatic clear_decode();
    ph = PH_OPCODE; seen = '0; short_ops = 1'b0; pend = '0; g3 = G3_NONE; modf = '0;
  endtask

  task automatic emit_length(input int unsigned len, input logic nh);
    xild_out_t r;
    r.length = len[4:0];
    r.not_handled = nh;
    lengths_q.push_back(r);
    clear_decode();
  endtask

  task automatic close_or_tail();
    if (pend == 0) emit_length(seen, 1'b0);
    else ph = PH_TAIL;
  endtask

  task automatic apply_entry(input byte unsigned entry, input int unsigned opb);
    int unsigned fixed, imm;
    fixed = entry & 15;
    if (entry & NX) begin
      emit_length(seen >= opb ? seen - opb : 0, 1'b1);
      return;
    end
    imm = fixed > opb ? fixed - opb : 0;
    if (entry & OS) imm += opnd_bytes();
    pend = imm[3:0];
    if (entry & MR) ph = PH_MODRM;
    else close_or_tail();
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic rs);
    int unsigned extra;
    if (rs) clear_decode();
    case (ph)
      PH_SECOND: begin
        seen++;
        apply_entry(map_two[b], 2);
      end
      PH_MODRM: begin
        extra = 0;
        seen++;
        if (b[7:6] == 2'd1) extra = 1;
        else if (b[7:6] == 2'd2) extra = 4;
        else if (b[7:6] == 2'd0 && b[2:0] == 3'd5) extra = 4;
        if ((b & RegMask) == 0) begin
          if (g3 == G3_BYTE) extra += 1;
          else if (g3 == G3_WORD) extra += opnd_bytes();
        end
        pend = pend + extra[3:0];
        modf = b[7:6];
        if (b[7:6] != 2'd3 && b[2:0] == 3'd4) ph = PH_SIB;
        else close_or_tail();
      end
      PH_SIB: begin
        seen++;
        if (modf == 2'd0 && b[2:0] == 3'd5) pend = pend + 4'd4;
        close_or_tail();
      end
      PH_TAIL: begin
        seen++;
        if (pend > 0) pend--;
        close_or_tail();
      end
      default: begin
        if (prefix_byte(b)) begin
          if (b == OpOpsize) short_ops = 1'b1;
          if (seen < MaxPrefix) seen++;
          ph = PH_OPCODE;
        end else begin
          seen++;
          if (b == OpEscape) ph = PH_SECOND;
          else begin
            g3 = (b == OpGrp3B) ? G3_BYTE : (b == OpGrp3V) ? G3_WORD : G3_NONE;
            apply_entry(map_one[b], 1);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    xild_out_t   want;
    int unsigned errs;
    if (!rst_ni) begin
      clear_decode();
      lengths_q.delete();
      fail_count_o      <= 0;
      lengths_pending_o <= 0;
    end else begin
      errs = 0;
      if (out_mon.valid && out_mon.ready) begin
        if (lengths_q.size() == 0) begin
          $display("%0t: unexpected length beat, actual length=%0d not_handled=%0b",
                   $time, out_mon.payload.length, out_mon.payload.not_handled);
          errs++;
        end else begin
          want = lengths_q.pop_front();
          if (want.length !== out_mon.payload.length) begin
            $display("%0t: length expected %0d actual %0d", $time,
                     want.length, out_mon.payload.length);
            errs++;
          end
          if (want.not_handled !== out_mon.payload.not_handled) begin
            $display("%0t: not_handled expected %0b actual %0b", $time,
                     want.not_handled, out_mon.payload.not_handled);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        decode_byte(in_mon.payload.code_byte, in_mon.payload.resync);
      if (errs != 0) fail_count_o <= fail_count_o + errs;
      lengths_pending_o <= unsigned'(lengths_q.size());
    end
  end
endmodule

/* tb/x86_instruction_length_decoder_top_tb.sv */
`timescale 1ns / 1ps
module x86_instruction_length_decoder_top_tb;
  import xild_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned fail_count, lengths_pending;

  xild_in_if  code_ch ();
  xild_out_if len_ch ();

  always #6 clk_i = ~clk_i;

  x86_instruction_length_decoder_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (code_ch.sink),
    .out_if (len_ch.source)
  );

  x86_instruction_length_decoder_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_mon            (code_ch.sink),
    .out_mon           (len_ch.sink),
    .fail_count_o      (fail_count),
    .lengths_pending_o (lengths_pending)
  );

  logic [7:0] stream_q[$];
  logic       resync_q[$];
  bit         feeding_done = 0;

  task automatic add_byte(input logic [7:0] b, input logic rs = 1'b0);
    stream_q.push_back(b);
    resync_q.push_back(rs);
  endtask

  function automatic logic [7:0] pick_prefix();
    logic [7:0] p [10] = '{8'h66, 8'hF0, 8'hF2, 8'hF3, 8'h26, 8'h2E, 8'h36, 8'h3E,
                            8'h64, 8'h65};
    return p[$urandom_range(9)];
  endfunction

  // instruction-shaped bytes: prefixes, opcode, ModRM/SIB/tail with random content
  task automatic add_instruction();
    int unsigned npre;
    logic [7:0] op, modrm;
    npre = ($urandom_range(9) == 0) ? $urandom_range(17) : $urandom_range(2);
    for (int i = 0; i < npre; i++) add_byte(pick_prefix());
    if ($urandom_range(3) == 0) begin
      add_byte(OpEscape);
      add_byte(8'($urandom_range(255)));
    end else begin
      do op = 8'($urandom_range(255)); while (op == OpEscape);
      if ($urandom_range(5) == 0) op = $urandom_range(1) ? OpGrp3B : OpGrp3V;
      add_byte(op);
    end
    modrm = 8'($urandom_range(255));
    if ($urandom_range(2) == 0) modrm[5:3] = 3'd0;
    add_byte(modrm);
    add_byte(8'($urandom_range(255)));
    for (int i = 0; i < 8; i++) add_byte(8'($urandom_range(255)));
  endtask

  initial begin
    // opcode, prefix or escape byte is interpreted by the stream itself,
    // so random trailing bytes just roll into the next instruction
    add_byte(8'h90);
    add_byte(8'h00); add_byte(8'h00);
    add_byte(8'hFF); add_byte(8'hFF);
    add_byte(8'h66); add_byte(8'hB8); add_byte(8'h12); add_byte(8'h34);
    add_byte(8'hF6); add_byte(8'hC0); add_byte(8'h7F);
    add_byte(8'hF7); add_byte(8'h80);
    repeat (8) add_byte(8'hAA);
    add_byte(8'h8B); add_byte(8'h04); add_byte(8'h25);
    repeat (4) add_byte(8'h55);
    add_byte(8'h0F); add_byte(8'h01); add_byte(8'h44); add_byte(8'h24); add_byte(8'h08);
    add_byte(8'h0F); add_byte(8'hFF);
    add_byte(8'hF1);
    add_byte(8'h67);
    repeat (17) add_byte(8'hF3);
    add_byte(8'hD6);
    add_byte(8'h81); add_byte(8'hC1);
    add_byte(8'h90, 1'b1);
    add_byte(8'h0F); add_byte(8'h85, 1'b1);
    while (stream_q.size() < 600) begin
      if ($urandom_range(9) == 0)
        add_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      else add_instruction();
    end
  end

  initial begin
    code_ch.valid = 1'b0;
    code_ch.payload = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (stream_q.size() > 0) begin
      int unsigned gap;
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(3);
      if (gap > 0) begin
        code_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      code_ch.valid <= 1'b1;
      code_ch.payload.code_byte <= stream_q.pop_front();
      code_ch.payload.resync <= resync_q.pop_front();
      @(posedge clk_i);
      while (!code_ch.ready) @(posedge clk_i);
    end
    code_ch.valid <= 1'b0;
    feeding_done = 1;
  end

  initial begin
    len_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (len_ch.ready && len_ch.valid || !len_ch.ready) begin
        int unsigned hold;
        hold = $urandom_range(3);
        len_ch.ready <= (hold == 0 || $urandom_range(3) == 0);
      end
    end
  end

  initial begin
    wait (feeding_done);
    @(posedge clk_i);
    while (lengths_pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && lengths_pending == 0)
      $display("x86_instruction_length_decoder_top_tb: PASS");
    else $display("x86_instruction_length_decoder_top_tb: FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("x86_instruction_length_decoder_top_tb: FAIL");
    $finish;
  end
endmodule
